/* rtl/xed_pkg.sv */
package xed_pkg;

    // Parser modes; codes 6 and 7 are never entered and behave as plain text.
    typedef enum logic [2:0] {
        MODE_PLAIN = 3'd0,
        MODE_AMP   = 3'd1,
        MODE_HASH  = 3'd2,
        MODE_HEX   = 3'd3,
        MODE_DEC   = 3'd4,
        MODE_NAMED = 3'd5
    } parse_mode_t;

    localparam int unsigned PEND_DEPTH = 5;
    localparam int unsigned MAX_OUT    = 6;
    localparam int unsigned NUM_ENT    = 5;

    localparam logic [20:0] CODE_MAX = 21'h10FFFF;

    localparam logic [7:0] CH_AMP  = 8'h26;   // '&'
    localparam logic [7:0] CH_HASH = 8'h23;   // '#'
    localparam logic [7:0] CH_SEMI = 8'h3B;   // ';'
    localparam logic [7:0] CH_X    = 8'h78;   // 'x'

    // Named entities, text after the '&', zero padded.
    localparam logic [7:0] ENT_TEXT [NUM_ENT][PEND_DEPTH] = '{
        '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},   // lt;
        '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},   // gt;
        '{8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},   // apos;
        '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},   // quot;
        '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00}    // amp;
    };
    localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd3, 3'd3, 3'd5, 3'd5, 3'd4};
    localparam logic [7:0] ENT_CHAR [NUM_ENT] = '{8'h3C, 8'h3E, 8'h27, 8'h22, 8'h26};

    typedef struct packed {
        parse_mode_t                     mode;
        logic [PEND_DEPTH-1:0][7:0]      pend;
        logic [2:0]                      pend_cnt;
        logic [20:0]                     acc;
    } parse_state_t;

    typedef struct packed {
        logic [2:0]                      cnt;
        logic [MAX_OUT-1:0][7:0]         bytes;
    } parse_result_t;

endpackage

/* rtl/xed_if.sv */
interface xed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       string_last;

    modport source (output valid, output in_byte, output string_last, input ready);
    modport sink   (input valid, input in_byte, input string_last, output ready);
endinterface

interface xed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;

    modport source (output valid, output out_byte, output run_last, output string_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input string_end,
                    output ready);
endinterface

/* rtl/xed_parse.sv */
module xed_parse
    import xed_pkg::*;
(
    input  parse_state_t  st,
    input  logic [7:0]    in_byte,
    input  logic          string_last,
    output parse_state_t  nxt,
    output parse_result_t res
);

    logic [2:0]              pos;
    logic [NUM_ENT-1:0]      ent_hit;
    logic [NUM_ENT-1:0]      ent_done;
    logic                    any_done;
    logic                    any_partial;
    logic [7:0]              done_char;
    logic [20:0]             acc_base;
    logic [3:0]              digit;
    logic [24:0]             acc_mul;
    logic [24:0]             acc_sum;
    logic [20:0]             acc_upd;
    logic [2:0]              n_p;
    logic                    raw_en;
    logic [7:0]              raw_b;
    logic                    code_en;
    logic [20:0]             code_v;
    logic [7:0][7:0]         tail;
    logic [2:0]              t_cnt;
    logic [MAX_OUT-1:0][7:0] p_ext;
    logic [2:0]              t_idx;
    logic [3:0]              total;

    // Named entity match against held prefix plus the new byte.
    always_comb
    begin
        logic ok;
        pos = (st.pend_cnt == 3'd0) ? 3'd0 : st.pend_cnt - 3'd1;
        any_done  = 1'b0;
        done_char = 8'h00;
        for (int e = 0; e < NUM_ENT; e++)
        begin
            ok = (ENT_LEN[e] > pos);
            for (int i = 0; i < PEND_DEPTH - 1; i++)
            begin
                if ((3'(i) < pos) && (ENT_TEXT[e][i] != st.pend[i+1]))
                    ok = 1'b0;
            end
            ent_hit[e]  = ok && (ENT_TEXT[e][pos] == in_byte);
            ent_done[e] = ent_hit[e] && ((pos + 3'd1) == ENT_LEN[e]);
            if (ent_done[e])
            begin
                any_done  = 1'b1;
                done_char = ENT_CHAR[e];
            end
        end
        any_partial = |(ent_hit & ~ent_done);
    end

    // Digit value and accumulator step with saturation.
    always_comb
    begin
        acc_base = (st.mode == MODE_HASH) ? 21'd0 : st.acc;
        digit    = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
            digit = 4'(in_byte - 8'h30);
        else if (st.mode == MODE_HEX && in_byte >= 8'h61 && in_byte <= 8'h66)
            digit = 4'(in_byte - 8'h57);
        else if (st.mode == MODE_HEX && in_byte >= 8'h41 && in_byte <= 8'h46)
            digit = 4'(in_byte - 8'h37);
        if (st.mode == MODE_HEX)
            acc_mul = {acc_base, 4'b0000};
        else
            acc_mul = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0};
        acc_sum = acc_mul + 25'(digit);
        acc_upd = (acc_sum > 25'(CODE_MAX)) ? CODE_MAX : acc_sum[20:0];
    end

    // Mode step, then end-of-string flush.
    always_comb
    begin
        nxt     = st;
        n_p     = 3'd0;
        raw_en  = 1'b0;
        raw_b   = in_byte;
        code_en = 1'b0;
        code_v  = acc_base;

        unique case (st.mode)
            MODE_AMP, MODE_NAMED:
            begin
                if (st.mode == MODE_AMP && in_byte == CH_HASH)
                begin
                    nxt.pend[1]  = CH_HASH;
                    nxt.pend_cnt = 3'd2;
                    nxt.acc      = 21'd0;
                    nxt.mode     = MODE_HASH;
                end
                else if (any_done)
                begin
                    raw_en       = 1'b1;
                    raw_b        = done_char;
                    nxt.mode     = MODE_PLAIN;
                    nxt.pend_cnt = 3'd0;
                    nxt.acc      = 21'd0;
                end
                else if (any_partial && st.pend_cnt < 3'(PEND_DEPTH))
                begin
                    nxt.pend[st.pend_cnt] = in_byte;
                    nxt.pend_cnt          = st.pend_cnt + 3'd1;
                    nxt.mode              = MODE_NAMED;
                end
                else
                begin
                    // broken match: pass prefix through, rescan byte as text
                    n_p          = st.pend_cnt;
                    nxt.mode     = MODE_PLAIN;
                    nxt.pend_cnt = 3'd0;
                    nxt.acc      = 21'd0;
                    if (in_byte == CH_AMP)
                    begin
                        nxt.pend[0]  = CH_AMP;
                        nxt.pend_cnt = 3'd1;
                        nxt.mode     = MODE_AMP;
                    end
                    else
                        raw_en = 1'b1;
                end
            end
            MODE_HASH, MODE_HEX, MODE_DEC:
            begin
                if (st.mode == MODE_HASH && in_byte == CH_X)
                begin
                    nxt.mode = MODE_HEX;
                    nxt.acc  = 21'd0;
                end
                else if (in_byte == CH_SEMI)
                begin
                    code_en      = 1'b1;
                    nxt.mode     = MODE_PLAIN;
                    nxt.pend_cnt = 3'd0;
                    nxt.acc      = 21'd0;
                end
                else
                begin
                    nxt.acc  = acc_upd;
                    nxt.mode = (st.mode == MODE_HASH) ? MODE_DEC : st.mode;
                end
            end
            default:
            begin
                nxt.mode     = MODE_PLAIN;
                nxt.pend_cnt = 3'd0;
                nxt.acc      = 21'd0;
                if (in_byte == CH_AMP)
                begin
                    nxt.pend[0]  = CH_AMP;
                    nxt.pend_cnt = 3'd1;
                    nxt.mode     = MODE_AMP;
                end
                else
                    raw_en = 1'b1;
            end
        endcase

        if (string_last)
        begin
            if (nxt.mode == MODE_AMP || nxt.mode == MODE_NAMED)
            begin
                // a prefix already flushed this word leaves only the new '&'
                if (n_p != 3'd0)
                begin
                    raw_en = 1'b1;
                    raw_b  = CH_AMP;
                end
                else
                    n_p = nxt.pend_cnt;
            end
            else if (nxt.mode == MODE_HASH || nxt.mode == MODE_HEX ||
                     nxt.mode == MODE_DEC)
            begin
                code_en = 1'b1;
                code_v  = nxt.acc;
            end
            nxt.mode     = MODE_PLAIN;
            nxt.pend_cnt = 3'd0;
            nxt.acc      = 21'd0;
        end
    end

    // Tail: UTF-8 of a code point or one raw byte.
    always_comb
    begin
        tail  = '0;
        t_cnt = 3'd0;
        if (code_en)
        begin
            if (code_v <= 21'h7F)
            begin
                tail[0] = code_v[7:0];
                t_cnt   = 3'd1;
            end
            else if (code_v <= 21'h7FF)
            begin
                tail[0] = 8'hC0 | {3'b000, code_v[10:6]};
                tail[1] = 8'h80 | {2'b00, code_v[5:0]};
                t_cnt   = 3'd2;
            end
            else if (code_v <= 21'hFFFF)
            begin
                tail[0] = 8'hE0 | {4'b0000, code_v[15:12]};
                tail[1] = 8'h80 | {2'b00, code_v[11:6]};
                tail[2] = 8'h80 | {2'b00, code_v[5:0]};
                t_cnt   = 3'd3;
            end
            else
            begin
                tail[0] = 8'hF0 | {5'b00000, code_v[20:18]};
                tail[1] = 8'h80 | {2'b00, code_v[17:12]};
                tail[2] = 8'h80 | {2'b00, code_v[11:6]};
                tail[3] = 8'h80 | {2'b00, code_v[5:0]};
                t_cnt   = 3'd4;
            end
        end
        else if (raw_en)
        begin
            tail[0] = raw_b;
            t_cnt   = 3'd1;
        end
    end

    // Result word list: held prefix bytes first, then the tail.
    always_comb
    begin
        p_ext = {8'h00, nxt.pend};
        for (int i = 0; i < MAX_OUT; i++)
        begin
            t_idx = 3'(i) - n_p;
            res.bytes[i] = (3'(i) < n_p) ? p_ext[i] : tail[t_idx];
        end
        total   = {1'b0, n_p} + {1'b0, t_cnt};
        res.cnt = (total > 4'(MAX_OUT)) ? 3'(MAX_OUT) : total[2:0];
    end

endmodule

/* rtl/xml_entity_to_utf8_decoder_unit.sv */
// XML character reference decoder, UTF-8 out.
//
// din  : escaped text, one byte per word; string_last marks the final byte
//        of a string and flushes any open reference or '&' prefix.
// dout : decoded bytes, one per word. run_last flags the last word caused by
//        an input byte, string_end the last word of the string.
//
// An accepted input byte is parsed in the same cycle against the parser
// state, and its 0 to 6 result words land in a result buffer. They appear on
// dout from the next cycle, one per cycle while dout is ready.
// Throughput: one input byte per cycle while each byte gives at most one
// word and dout is ready; a byte that gives more words holds din until the
// single output port has drained the buffer. The next byte is taken in the
// same cycle as the buffer's last word leaves. Bytes that give no word ('&',
// digits) are taken and nothing appears. A stall on dout holds the current
// word; din.ready stays low while any word other than a departing last one
// sits in the buffer. Reset returns the parser to plain text and empties the
// buffer.
module xml_entity_to_utf8_decoder_unit
    import xed_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    xed_in_if.sink            din,
    xed_out_if.source         dout
);

    parse_mode_t                 mode_reg;
    logic [2:0]                  pend_cnt_reg;
    logic [20:0]                 acc_reg;
    logic [PEND_DEPTH-1:0][7:0]  pend_reg;

    logic [MAX_OUT-1:0][7:0]     buf_reg;
    logic [2:0]                  rem_reg;
    logic [2:0]                  idx_reg;
    logic                        last_reg;

    parse_state_t                st;
    parse_state_t                st_next;
    parse_result_t               res;
    logic                        in_fire;
    logic                        out_fire;

    assign st = '{mode: mode_reg, pend: pend_reg, pend_cnt: pend_cnt_reg, acc: acc_reg};

    xed_parse u_parse (
        .st          (st),
        .in_byte     (din.in_byte),
        .string_last (din.string_last),
        .nxt         (st_next),
        .res         (res)
    );

    // buffer frees up as its last word is taken
    assign out_fire  = dout.valid && dout.ready;
    assign din.ready = (rem_reg == 3'd0) || ((rem_reg == 3'd1) && dout.ready);
    assign in_fire   = din.valid && din.ready;

    assign dout.valid      = (rem_reg != 3'd0);
    assign dout.out_byte   = buf_reg[idx_reg];
    assign dout.run_last   = (rem_reg == 3'd1);
    assign dout.string_end = (rem_reg == 3'd1) && last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_PLAIN;
            pend_cnt_reg <= 3'd0;
            acc_reg      <= 21'd0;
            rem_reg      <= 3'd0;
            idx_reg      <= 3'd0;
            last_reg     <= 1'b0;
        end
        else if (in_fire)
        begin
            mode_reg     <= st_next.mode;
            pend_cnt_reg <= st_next.pend_cnt;
            acc_reg      <= st_next.acc;
            rem_reg      <= res.cnt;
            idx_reg      <= 3'd0;
            last_reg     <= din.string_last;
        end
        else if (out_fire)
        begin
            rem_reg <= rem_reg - 3'd1;
            idx_reg <= idx_reg + 3'd1;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pend_reg <= st_next.pend;
            buf_reg  <= res.bytes;
        end
    end

endmodule

/* test/tb.sv */
module tb;
    import xed_pkg::*;

    // One decoded word as it should appear on dout.
    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       string_end;
    } dec_word_t;

    // A watchdog trip means no word moved on either side for this long.
    // The worst correct gap is one sender pause plus one receiver stall.
    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic clk;
    logic rst_n;

    xed_in_if  din_if ();
    xed_out_if dout_if ();

    xml_entity_to_utf8_decoder_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    // Entity names after the '&', and the character each one stands for.
    string ent_name [NUM_ENT] = '{"lt;", "gt;", "apos;", "quot;", "amp;"};
    string ent_out = "<>'\"&";

    // Shadow parser state.
    parse_mode_t cur_mode;
    logic [7:0]  held [PEND_DEPTH];
    int unsigned held_cnt;
    int unsigned code_acc;

    logic [7:0] step_words [$];   // words caused by the byte being predicted
    dec_word_t  decoded_q [$];    // words still owed by the block
    logic [7:0] text_q [$];       // string being sent

    bit src_idle;
    bit sink_idle;

    int unsigned bytes_sent;
    int unsigned strings_sent;
    int unsigned words_checked;
    int unsigned mismatches;
    int unsigned idle_cycles;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decode predictor
    // ------------------------------------------------------------------

    // At most MAX_OUT words per input byte.
    function automatic void push_word(input logic [7:0] b);
        if (step_words.size() < MAX_OUT)
            step_words.push_back(b);
    endfunction

    function automatic void emit_utf8(input int unsigned c);
        if (c <= 'h7F)
        begin
            push_word(8'(c));
        end
        else if (c <= 'h7FF)
        begin
            push_word(8'hC0 | 8'((c >> 6) & 'h1F));
            push_word(8'h80 | 8'(c & 'h3F));
        end
        else if (c <= 'hFFFF)
        begin
            push_word(8'hE0 | 8'((c >> 12) & 'h0F));
            push_word(8'h80 | 8'((c >> 6) & 'h3F));
            push_word(8'h80 | 8'(c & 'h3F));
        end
        else
        begin
            push_word(8'hF0 | 8'((c >> 18) & 'h07));
            push_word(8'h80 | 8'((c >> 12) & 'h3F));
            push_word(8'h80 | 8'((c >> 6) & 'h3F));
            push_word(8'h80 | 8'(c & 'h3F));
        end
    endfunction

    function automatic void back_to_text();
        cur_mode = MODE_PLAIN;
        held_cnt = 0;
        code_acc = 0;
    endfunction

    // Pass the held '&' sequence through unchanged.
    function automatic void flush_held();
        for (int unsigned i = 0; i < held_cnt && i < PEND_DEPTH; i++)
            push_word(held[i]);
        back_to_text();
    endfunction

    function automatic void text_byte(input logic [7:0] b);
        if (b == CH_AMP)
        begin
            held[0]  = b;
            held_cnt = 1;
            cur_mode = MODE_AMP;
        end
        else
        begin
            push_word(b);
        end
    endfunction

    // Anything but ';' is a digit; bad digits count as zero. Saturates.
    function automatic void num_digit(input logic [7:0] b, input int unsigned radix);
        int unsigned d;
        int unsigned nv;
        if (b == CH_SEMI)
        begin
            emit_utf8(code_acc);
            back_to_text();
            return;
        end
        d = 0;
        if (b >= "0" && b <= "9")
            d = 32'(b - 8'("0"));
        else if (radix == 16 && b >= "a" && b <= "f")
            d = 32'(b - 8'("a")) + 10;
        else if (radix == 16 && b >= "A" && b <= "F")
            d = 32'(b - 8'("A")) + 10;
        nv = code_acc * radix + d;
        if (nv > CODE_MAX)
            nv = CODE_MAX;
        code_acc = nv;
    endfunction

    // Match against the entity names; a broken match is passed through and
    // the breaking byte is handled again as plain text.
    function automatic void entity_byte(input logic [7:0] b);
        int unsigned pos;
        bit          partial;
        bit          ok;
        pos     = (held_cnt > 0) ? held_cnt - 1 : 0;
        partial = 1'b0;
        for (int unsigned e = 0; e < NUM_ENT; e++)
        begin
            ok = ent_name[e].len() > pos;
            for (int unsigned i = 0; ok && i < pos && i + 1 < PEND_DEPTH; i++)
                if (8'(ent_name[e][i]) != held[i + 1])
                    ok = 1'b0;
            if (ok && 8'(ent_name[e][pos]) == b)
            begin
                if (pos + 1 == ent_name[e].len())
                begin
                    push_word(8'(ent_out[e]));
                    back_to_text();
                    return;
                end
                partial = 1'b1;
            end
        end
        if (partial && held_cnt < PEND_DEPTH)
        begin
            held[held_cnt] = b;
            held_cnt++;
            cur_mode = MODE_NAMED;
        end
        else
        begin
            flush_held();
            text_byte(b);
        end
    endfunction

    // Advance the shadow parser by one accepted byte and queue its words.
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        int unsigned n;
        step_words.delete();
        case (cur_mode)
            MODE_AMP:
            begin
                if (b == CH_HASH)
                begin
                    held[1]  = b;
                    held_cnt = 2;
                    code_acc = 0;
                    cur_mode = MODE_HASH;
                end
                else
                begin
                    entity_byte(b);
                end
            end
            MODE_NAMED:
                entity_byte(b);
            MODE_HASH:
            begin
                code_acc = 0;
                if (b == CH_X)
                begin
                    cur_mode = MODE_HEX;
                end
                else
                begin
                    // "&#X" and friends fall into decimal
                    cur_mode = MODE_DEC;
                    num_digit(b, 10);
                end
            end
            MODE_HEX:
                num_digit(b, 16);
            MODE_DEC:
                num_digit(b, 10);
            default:
            begin
                back_to_text();
                text_byte(b);
            end
        endcase

        // End of string: emit what a reference has so far, or pass the prefix.
        if (last)
        begin
            if (cur_mode == MODE_AMP || cur_mode == MODE_NAMED)
                flush_held();
            else if (cur_mode == MODE_HASH || cur_mode == MODE_HEX || cur_mode == MODE_DEC)
                emit_utf8(code_acc);
            back_to_text();
        end

        n = step_words.size();
        for (int unsigned i = 0; i < n; i++)
            decoded_q.push_back('{data: step_words[i],
                                  run_last: (i == n - 1),
                                  string_end: (last && i == n - 1)});
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Valid stays high after a handshake until the next falling edge, where it
    // either carries the next byte or drops for the gap.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 19) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            din_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        din_if.valid       <= 1'b1;
        din_if.in_byte     <= b;
        din_if.string_last <= last;
        @(posedge clk);
        while (!din_if.ready)
            @(posedge clk);
        decode_byte(b, last);
        bytes_sent++;
    endtask

    // Send text_q as one string; last flag on its final byte.
    task automatic send_text();
        for (int unsigned i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
        strings_sent++;
    endtask

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(8'(s[i]));
    endfunction

    task automatic send_str(input string s);
        text_q.delete();
        add_str(s);
        send_text();
    endtask

    // Random string: about half references with random content, some cut short or
    // altered, the rest plain bytes, '&' noise and empty references.
    function automatic void build_text();
        int unsigned nseg;
        int unsigned code;
        int unsigned cut;
        int unsigned e;
        bit          hex;
        string       digits;
        logic [7:0]  ch;
        text_q.delete();
        nseg = $urandom_range(1, 4);
        repeat (nseg)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    repeat ($urandom_range(1, 3))
                        text_q.push_back(8'($urandom_range(0, 255)));
                end
                3, 4:
                begin
                    // named entity, sometimes cut short or with random bytes changed
                    e   = $urandom_range(0, NUM_ENT - 1);
                    cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ent_name[e].len() - 1)
                                                      : ent_name[e].len();
                    text_q.push_back(CH_AMP);
                    for (int unsigned i = 0; i < cut; i++)
                    begin
                        ch = 8'(ent_name[e][i]);
                        if ($urandom_range(0, 9) == 0)
                            ch = 8'($urandom_range(0, 255));
                        text_q.push_back(ch);
                    end
                end
                5, 6, 7:
                begin
                    // numeric reference; code points lean on the UTF-8 size edges
                    case ($urandom_range(0, 11))
                        0:  code = 0;
                        1:  code = 'h7F;
                        2:  code = 'h80;
                        3:  code = 'h7FF;
                        4:  code = 'h800;
                        5:  code = 'hFFFF;
                        6:  code = 'h10000;
                        7:  code = CODE_MAX;
                        8:  code = $urandom_range('h110000, 'h0FFFFFFF);
                        9:  code = $urandom_range('hD800, 'hDFFF);
                        10: code = $urandom_range(0, 'h7FF);
                        default: code = $urandom_range(0, CODE_MAX);
                    endcase
                    hex = 1'($urandom_range(0, 1));
                    text_q.push_back(CH_AMP);
                    text_q.push_back(CH_HASH);
                    if (hex)
                        text_q.push_back(($urandom_range(0, 7) == 0) ? 8'("X") : CH_X);
                    digits = hex ? $sformatf("%0h", code) : $sformatf("%0d", code);
                    if ($urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, 3))
                            text_q.push_back(8'("0"));
                    for (int i = 0; i < digits.len(); i++)
                    begin
                        if ($urandom_range(0, 11) == 0)
                            text_q.push_back(8'($urandom_range(0, 255)));
                        ch = 8'(digits[i]);
                        if (hex && ch >= "a" && ch <= "f" && $urandom_range(0, 1))
                            ch = ch - 8'h20;
                        text_q.push_back(ch);
                    end
                    if ($urandom_range(0, 3) != 0)
                        text_q.push_back(CH_SEMI);
                end
                8:
                begin
                    text_q.push_back(CH_AMP);
                    repeat ($urandom_range(1, 4))
                    begin
                        case ($urandom_range(0, 7))
                            0: ch = CH_AMP;
                            1: ch = CH_HASH;
                            2: ch = CH_X;
                            3: ch = CH_SEMI;
                            4: ch = "a";
                            5: ch = "q";
                            6: ch = "l";
                            default: ch = 8'($urandom_range(0, 255));
                        endcase
                        text_q.push_back(ch);
                    end
                end
                default:
                begin
                    case ($urandom_range(0, 2))
                        0: add_str("&#;");
                        1: add_str("&#x;");
                        default: add_str("&");
                    endcase
                end
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side: per-word random stall, then wait for the word
    // ------------------------------------------------------------------
    initial
    begin : drain_words
        int unsigned hold;
        dout_if.ready = 1'b0;
        forever
        begin
            hold = sink_idle ? $urandom_range(0, 19) : 0;
            @(negedge clk);
            if (hold > 0)
            begin
                dout_if.ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            dout_if.ready <= 1'b1;
            @(posedge clk);
            while (!dout_if.valid)
                @(posedge clk);
        end
    end

    // Every word leaving dout is checked against the oldest expectation.
    always @(posedge clk)
    begin : check_words
        dec_word_t want;
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            if (decoded_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %02h run_last %0b string_end %0b",
                             dout_if.out_byte, dout_if.run_last, dout_if.string_end);
            end
            else
            begin
                want = decoded_q.pop_front();
                words_checked++;
                if (dout_if.out_byte !== want.data || dout_if.run_last !== want.run_last
                    || dout_if.string_end !== want.string_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                 words_checked, want.data, want.run_last, want.string_end,
                                 dout_if.out_byte, dout_if.run_last, dout_if.string_end);
                end
            end
        end
    end

    // Watchdog on handshake activity.
    always @(posedge clk)
    begin
        if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles, %0d words owed",
                     idle_cycles, decoded_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Plain bytes at the extremes, zero is not a terminator.
    task automatic test_plain_bytes();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h41, 1'b1);
    endtask

    // Full entity, longest prefix flushed at end of string, and a broken
    // prefix whose breaking '&' opens a new sequence.
    task automatic test_named_entities();
        send_str("&gt;");
        send_str("&quot");
        send_str("&ap&");
    endtask

    // Empty references and upper-case X read as decimal.
    task automatic test_numeric_refs();
        send_str("&#");
        send_str("&#x;");
        send_str("&#X9;");
    endtask

    // Random strings until about n more bytes went in. Every sixth string the
    // sender holds off until all owed words are out.
    task automatic test_random_text(input int unsigned n, input bit with_idle);
        int unsigned stop_at;
        int unsigned k;
        stop_at = bytes_sent + n;
        k = 0;
        while (bytes_sent < stop_at)
        begin
            build_text();
            src_idle  = with_idle && ($urandom_range(0, 4) != 0);
            sink_idle = with_idle && ($urandom_range(0, 4) != 0);
            send_text();
            if (k % 6 == 0)
            begin
                @(negedge clk);
                din_if.valid <= 1'b0;
                while (decoded_q.size() != 0)
                    @(posedge clk);
            end
            k++;
        end
    endtask

    initial
    begin
        din_if.valid       = 1'b0;
        din_if.in_byte     = 8'h00;
        din_if.string_last = 1'b0;
        rst_n       = 1'b0;
        src_idle    = 1'b1;
        sink_idle   = 1'b1;
        back_to_text();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_plain_bytes();
        test_named_entities();
        test_numeric_refs();
        test_random_text(300, 1'b1);
        test_random_text(60, 1'b0);

        @(negedge clk);
        din_if.valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes in %0d strings, checked %0d decoded words, %0d mismatches",
                 bytes_sent, strings_sent, words_checked, mismatches);
        $display("covered named, hex and decimal references, saturation, 1-4 byte UTF-8, "
                 , "broken prefixes, with and without stalls");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* xml_entity_to_utf8_decoder_unit.f */
rtl/xed_pkg.sv
rtl/xed_if.sv
rtl/xed_parse.sv
rtl/xml_entity_to_utf8_decoder_unit.sv
test/tb.sv
